/* rtl/core/rled_pkg.sv */
package rled_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned QDEPTH  = 3;
    localparam int unsigned QCNT_W  = 2;

    typedef enum logic [4:0] {
        PH_MARKER = 5'b00001,
        PH_BODY   = 5'b00010,
        PH_COUNT  = 5'b00100,
        PH_VALUE  = 5'b01000,
        PH_DRAIN  = 5'b10000
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_RUN = 2'd0,
        KIND_OK  = 2'd1,
        KIND_ERR = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  run_value;
        logic [BYTE_W-1:0]  run_length;
        logic               last;
    } result_t;

    // up to two results written into the queue in one cycle
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

    typedef struct packed {
        logic not_empty;
        logic has_room;
    } q_status_t;

    function automatic result_t mk_status(kind_t k);
        result_t r;
        r.kind       = k;
        r.run_value  = '0;
        r.run_length = '0;
        r.last       = 1'b1;
        return r;
    endfunction

    function automatic result_t mk_run(logic [BYTE_W-1:0] v, logic [BYTE_W-1:0] n,
                                       logic last);
        result_t r;
        r.kind       = KIND_RUN;
        r.run_value  = v;
        r.run_length = n;
        r.last       = last;
        return r;
    endfunction

endpackage

/* rtl/core/rled_if.sv */
interface rled_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_final;

    modport source (output valid, output in_byte, output is_final, input ready);
    modport sink   (input valid, input in_byte, input is_final, output ready);
endinterface

interface rled_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] run_value;
    logic [7:0] run_length;
    logic       out_last;

    modport source (output valid, output kind, output run_value, output run_length,
                    output out_last, input ready);
    modport sink   (input valid, input kind, input run_value, input run_length,
                    input out_last, output ready);
endinterface

/* rtl/core/rled_res_q.sv */
module rled_res_q (
    input  logic                clk,
    input  logic                rst_n,
    input  rled_pkg::push_t     push,
    input  logic                pop,
    output rled_pkg::result_t   head,
    output rled_pkg::q_status_t status
);

    logic [rled_pkg::QCNT_W-1:0] count_reg, count_next;
    logic [rled_pkg::QCNT_W-1:0] base;
    rled_pkg::result_t           entry_reg  [rled_pkg::QDEPTH];
    rled_pkg::result_t           entry_next [rled_pkg::QDEPTH];

    always_comb
    begin
        base       = count_reg - {{(rled_pkg::QCNT_W-1){1'b0}}, pop};
        count_next = base + {{(rled_pkg::QCNT_W-1){1'b0}}, push.v0}
                          + {{(rled_pkg::QCNT_W-1){1'b0}}, push.v1};
        entry_next = entry_reg;
        if (pop)
        begin
            for (int i = 0; i < int'(rled_pkg::QDEPTH) - 1; i++)
                entry_next[i] = entry_reg[i+1];
        end
        for (int i = 0; i < int'(rled_pkg::QDEPTH); i++)
        begin
            if (push.v0 && base == rled_pkg::QCNT_W'(i))
                entry_next[i] = push.r0;
            if (push.v1 && base + 1'b1 == rled_pkg::QCNT_W'(i))
                entry_next[i] = push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign head             = entry_reg[0];
    assign status.not_empty = (count_reg != '0);
    // room for a worst-case item (two results) without looking at the sink
    assign status.has_room  = (count_reg <= rled_pkg::QCNT_W'(1));

endmodule

/* rtl/core/escape_marker_rle_decoder.sv */
// Escape-marker RLE decoder. Takes one compressed byte per cycle while the
// result queue has room; the first byte of each stream is the marker,
// "marker, count, value" becomes one run descriptor and "marker, 0"
// terminates. Each byte produces zero, one or two result transactions (run
// descriptors and a final ok/error status), held in a three-entry result
// queue. Input is taken in the same cycle as long as the queue holds at most
// one result, so with an always-ready sink the block sustains one byte per
// clock; a byte that yields two results holds the input off while the extra
// result drains. expected_length should only be written between streams.
module escape_marker_rle_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    rled_in_if.sink     in_stream,
    rled_out_if.source  out_stream
);

    logic [rled_pkg::LEN_W-1:0]  exp_len_reg;
    rled_pkg::phase_t            phase_reg, phase_next;
    logic [rled_pkg::BYTE_W-1:0] esc_reg, esc_next;
    logic [rled_pkg::BYTE_W-1:0] pend_reg, pend_next;
    logic [rled_pkg::LEN_W-1:0]  bw_reg, bw_next;

    rled_pkg::push_t     push;
    rled_pkg::result_t   head;
    rled_pkg::q_status_t q_status;

    logic                        accept;
    logic                        fin;
    logic [rled_pkg::BYTE_W-1:0] b;
    logic [rled_pkg::LEN_W:0]    bw_plus_b;

    assign in_stream.ready = q_status.has_room;
    assign accept          = in_stream.valid & in_stream.ready;
    assign b               = in_stream.in_byte;
    assign fin             = in_stream.is_final;
    assign bw_plus_b       = {1'b0, bw_reg} + {{(rled_pkg::LEN_W+1-rled_pkg::BYTE_W){1'b0}}, b};

    always_comb
    begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        pend_next  = pend_reg;
        bw_next    = bw_reg;
        push       = '0;
        if (accept)
        begin
            unique case (phase_reg)
                rled_pkg::PH_MARKER:
                begin
                    esc_next  = b;
                    bw_next   = '0;
                    pend_next = '0;
                    if (fin)
                    begin
                        push.v0 = 1'b1;
                        push.r0 = rled_pkg::mk_status(rled_pkg::KIND_ERR);
                    end
                    else
                        phase_next = rled_pkg::PH_BODY;
                end
                rled_pkg::PH_BODY:
                begin
                    if (b != esc_reg)
                    begin
                        if (bw_reg >= exp_len_reg)
                        begin
                            push.v0    = 1'b1;
                            push.r0    = rled_pkg::mk_status(rled_pkg::KIND_ERR);
                            phase_next = fin ? rled_pkg::PH_MARKER : rled_pkg::PH_DRAIN;
                        end
                        else
                        begin
                            push.v0 = 1'b1;
                            push.r0 = rled_pkg::mk_run(b, rled_pkg::BYTE_W'(1), !fin);
                            bw_next = bw_reg + 1'b1;
                            if (fin)
                            begin
                                // literal on the final byte: no terminator
                                push.v1    = 1'b1;
                                push.r1    = rled_pkg::mk_status(rled_pkg::KIND_ERR);
                                phase_next = rled_pkg::PH_MARKER;
                            end
                        end
                    end
                    else if (fin)
                    begin
                        push.v0    = 1'b1;
                        push.r0    = rled_pkg::mk_status(rled_pkg::KIND_ERR);
                        phase_next = rled_pkg::PH_MARKER;
                    end
                    else
                        phase_next = rled_pkg::PH_COUNT;
                end
                rled_pkg::PH_COUNT:
                begin
                    if (b == '0)
                    begin
                        push.v0    = 1'b1;
                        push.r0    = rled_pkg::mk_status((fin && bw_reg == exp_len_reg)
                                                         ? rled_pkg::KIND_OK
                                                         : rled_pkg::KIND_ERR);
                        phase_next = fin ? rled_pkg::PH_MARKER : rled_pkg::PH_DRAIN;
                    end
                    else if (fin || bw_plus_b > {1'b0, exp_len_reg})
                    begin
                        push.v0    = 1'b1;
                        push.r0    = rled_pkg::mk_status(rled_pkg::KIND_ERR);
                        phase_next = fin ? rled_pkg::PH_MARKER : rled_pkg::PH_DRAIN;
                    end
                    else
                    begin
                        pend_next  = b;
                        phase_next = rled_pkg::PH_VALUE;
                    end
                end
                rled_pkg::PH_VALUE:
                begin
                    push.v0   = 1'b1;
                    push.r0   = rled_pkg::mk_run(b, pend_reg, !fin);
                    bw_next   = bw_reg + {{(rled_pkg::LEN_W-rled_pkg::BYTE_W){1'b0}}, pend_reg};
                    pend_next = '0;
                    if (fin)
                    begin
                        push.v1    = 1'b1;
                        push.r1    = rled_pkg::mk_status(rled_pkg::KIND_ERR);
                        phase_next = rled_pkg::PH_MARKER;
                    end
                    else
                        phase_next = rled_pkg::PH_BODY;
                end
                default:
                begin
                    // draining after terminator or error
                    if (fin)
                        phase_next = rled_pkg::PH_MARKER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_len_reg <= '0;
            phase_reg   <= rled_pkg::PH_MARKER;
            esc_reg     <= '0;
            pend_reg    <= '0;
            bw_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                exp_len_reg <= cfg_wr_data;
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            pend_reg  <= pend_next;
            bw_reg    <= bw_next;
        end
    end

    rled_res_q u_res_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (out_stream.valid & out_stream.ready),
        .head   (head),
        .status (q_status)
    );

    assign out_stream.valid      = q_status.not_empty;
    assign out_stream.kind       = head.kind;
    assign out_stream.run_value  = head.run_value;
    assign out_stream.run_length = head.run_length;
    assign out_stream.out_last   = head.last;

endmodule

/* dv/escape_marker_rle_decoder_tb.sv */
module escape_marker_rle_decoder_tb;

    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned HOLD_CYCLES     = 300;
    localparam int unsigned BYTES_PER_PHASE = 50;
    localparam int unsigned MAX_REPORTS     = 10;

    typedef struct packed {
        logic [7:0] b;
        logic       fin;
    } stream_byte_t;

    // Decoder prediction plus the queue of results still owed by the block.
    class rle_run_scoreboard;
        logic [15:0]        target_len;
        rled_pkg::phase_t   phase;
        logic [7:0]         marker;
        logic [7:0]         held_count;
        logic [15:0]        produced;
        rled_pkg::result_t  due_runs[$];
        rled_pkg::result_t  fresh[$];
        int unsigned        fail_count;

        function new();
            target_len = '0;
            phase      = rled_pkg::PH_MARKER;
            marker     = '0;
            held_count = '0;
            produced   = '0;
            fail_count = 0;
        endfunction

        function rled_pkg::result_t make_result(rled_pkg::kind_t k, logic [7:0] v,
                                                logic [7:0] n);
            rled_pkg::result_t r;
            r.kind       = k;
            r.run_value  = v;
            r.run_length = n;
            r.last       = 1'b0;
            return r;
        endfunction

        function void close_stream(rled_pkg::kind_t k, logic fin);
            fresh.push_back(make_result(k, 8'd0, 8'd0));
            phase = fin ? rled_pkg::PH_MARKER : rled_pkg::PH_DRAIN;
        endfunction

        function void note_byte(logic [7:0] b, logic fin);
            logic [16:0] reach;
            fresh.delete();
            case (phase)
                rled_pkg::PH_MARKER:
                begin
                    marker     = b;
                    produced   = '0;
                    held_count = '0;
                    if (fin)
                        close_stream(rled_pkg::KIND_ERR, 1'b1);
                    else
                        phase = rled_pkg::PH_BODY;
                end
                rled_pkg::PH_BODY:
                begin
                    if (b != marker)
                    begin
                        if (produced >= target_len)
                        begin
                            close_stream(rled_pkg::KIND_ERR, fin);
                        end
                        else
                        begin
                            fresh.push_back(make_result(rled_pkg::KIND_RUN, b, 8'd1));
                            produced = produced + 16'd1;
                            if (fin)
                                close_stream(rled_pkg::KIND_ERR, 1'b1);
                        end
                    end
                    else if (fin)
                    begin
                        close_stream(rled_pkg::KIND_ERR, 1'b1);
                    end
                    else
                    begin
                        phase = rled_pkg::PH_COUNT;
                    end
                end
                rled_pkg::PH_COUNT:
                begin
                    reach = {1'b0, produced} + {9'd0, b};
                    if (b == 8'd0)
                        close_stream((fin && produced == target_len) ? rled_pkg::KIND_OK
                                                                     : rled_pkg::KIND_ERR,
                                     fin);
                    else if (fin || reach > {1'b0, target_len})
                        close_stream(rled_pkg::KIND_ERR, fin);
                    else
                    begin
                        held_count = b;
                        phase      = rled_pkg::PH_VALUE;
                    end
                end
                rled_pkg::PH_VALUE:
                begin
                    fresh.push_back(make_result(rled_pkg::KIND_RUN, b, held_count));
                    produced   = produced + {8'd0, held_count};
                    held_count = '0;
                    if (fin)
                        close_stream(rled_pkg::KIND_ERR, 1'b1);
                    else
                        phase = rled_pkg::PH_BODY;
                end
                default:
                begin
                    if (fin)
                        phase = rled_pkg::PH_MARKER;
                end
            endcase
            if (fresh.size() > 0)
                fresh[fresh.size() - 1].last = 1'b1;
            foreach (fresh[i])
                due_runs.push_back(fresh[i]);
        endfunction

        function void complain(string msg);
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        function void check_result(rled_pkg::result_t got);
            rled_pkg::result_t want;
            if (due_runs.size() == 0)
            begin
                complain($sformatf("unexpected result: kind %0d value %0d length %0d last %0b",
                                   got.kind, got.run_value, got.run_length, got.last));
                return;
            end
            want = due_runs.pop_front();
            if (got.kind !== want.kind || got.run_value !== want.run_value ||
                got.run_length !== want.run_length || got.last !== want.last)
                complain($sformatf({"mismatch: expected kind %0d value %0d length %0d last %0b,",
                                    " got kind %0d value %0d length %0d last %0b"},
                                   want.kind, want.run_value, want.run_length, want.last,
                                   got.kind, got.run_value, got.run_length, got.last));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    rled_in_if  in_if();
    rled_out_if out_if();

    escape_marker_rle_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_stream   (in_if),
        .out_stream  (out_if)
    );

    rle_run_scoreboard tracker;
    stream_byte_t      stream_q[$];
    int unsigned       send_gap_pct;
    int unsigned       stall_pct;
    bit                hold_request;
    int unsigned       cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        out_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            out_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Signals are stable by the falling edge; a transaction here completes at the next rise.
    always @(negedge clk)
    begin
        rled_pkg::result_t got;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            got.kind       = rled_pkg::kind_t'(out_if.kind);
            got.run_value  = out_if.run_value;
            got.run_length = out_if.run_length;
            got.last       = out_if.out_last;
            tracker.check_result(got);
        end
    end

    function automatic void add_byte(logic [7:0] b, logic fin);
        stream_q.push_back('{b: b, fin: fin});
    endfunction

    // Well-formed stream decoding to exactly total bytes.
    function automatic void compose_stream(int unsigned total);
        logic [7:0]  mk;
        int unsigned rem;
        int unsigned cnt;
        stream_q.delete();
        mk  = 8'($urandom_range(255));
        rem = total;
        add_byte(mk, 1'b0);
        while (rem > 0)
        begin
            if (rem > 255 || $urandom_range(2) == 0)
            begin
                if (rem > 255)
                    cnt = $urandom_range(255, 200);
                else if ($urandom_range(3) == 0)
                    cnt = rem;
                else
                    cnt = $urandom_range(rem, 1);
                add_byte(mk, 1'b0);
                add_byte(8'(cnt), 1'b0);
                add_byte(8'($urandom_range(255)), 1'b0);
                rem -= cnt;
            end
            else
            begin
                add_byte(mk + 8'd1 + 8'($urandom_range(254)), 1'b0);
                rem--;
            end
        end
        add_byte(mk, 1'b0);
        add_byte(8'd0, 1'b1);
    endfunction

    function automatic void build_random_stream(int unsigned len, bit first);
        int unsigned pick;
        int unsigned total;
        int unsigned k;
        int unsigned n;
        logic [7:0]  mk;
        pick  = first ? 0 : $urandom_range(99);
        total = len;
        if (len > 2000 && !first)
            total = $urandom_range(40);
        else if (pick >= 40 && pick < 50)
            total = (len > 0 && $urandom_range(1) == 1) ?
                    len - $urandom_range(1, (len < 3) ? len : 3) : len + $urandom_range(1, 3);
        compose_stream(total);
        mk = stream_q[0].b;
        if (pick >= 50 && pick < 70)
        begin
            // cut short anywhere, down to a lone marker byte
            k = $urandom_range(1, stream_q.size() - 1);
            while (stream_q.size() > k)
                void'(stream_q.pop_back());
            stream_q[k - 1].fin = 1'b1;
        end
        else if (pick >= 70 && pick < 80)
        begin
            // junk after the terminator
            stream_q[stream_q.size() - 1].fin = 1'b0;
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                add_byte(8'($urandom_range(255)), i == n - 1);
        end
        else if (pick >= 80 && pick < 90)
        begin
            stream_q.delete();
            n = $urandom_range(1, 8);
            add_byte(mk, n == 1);
            for (int i = 1; i < n; i++)
                add_byte(($urandom_range(3) == 0) ? mk : 8'($urandom_range(255)), i == n - 1);
        end
        else if (pick >= 90)
        begin
            // one literal too many before the terminator
            void'(stream_q.pop_back());
            void'(stream_q.pop_back());
            add_byte(mk + 8'd1 + 8'($urandom_range(254)), 1'b0);
            add_byte(mk, 1'b0);
            add_byte(8'd0, 1'b1);
        end
    endfunction

    // Called just after a rising edge; returns just after the accepting edge.
    task automatic push_byte(input stream_byte_t item);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid    <= 1'b1;
        in_if.in_byte  <= item.b;
        in_if.is_final <= item.fin;
        @(negedge clk);
        while (!in_if.ready)
            @(negedge clk);
        tracker.note_byte(item.b, item.fin);
        @(posedge clk);
    endtask

    task automatic play_stream();
        foreach (stream_q[i])
            push_byte(stream_q[i]);
        stream_q.delete();
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (tracker.due_runs.size() != 0)
            @(posedge clk);
        // bytes that give no result may still be in flight
        repeat (4) @(posedge clk);
    endtask

    task automatic write_length(input logic [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        tracker.target_len = v;
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        int unsigned phase_lengths[8];
        int unsigned sent;
        int unsigned streams;
        phase_lengths = '{0, 1, 17, 255, 256, 1000, 65535, 3};
        tracker         = new();
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        in_if.valid     = 1'b0;
        in_if.in_byte   = '0;
        in_if.is_final  = 1'b0;
        send_gap_pct    = 0;
        stall_pct       = 0;
        hold_request    = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // length 0 from reset: lone marker, empty good stream, literal overflow
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b1);
        add_byte(8'h7E, 1'b0);
        add_byte(8'h41, 1'b1);
        play_stream();
        wait_drained();
        write_length(16'd4);
        // good stream with a run of the value zero
        add_byte(8'hAA, 1'b0);
        add_byte(8'h55, 1'b0);
        add_byte(8'hAA, 1'b0);
        add_byte(8'h03, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hAA, 1'b0);
        add_byte(8'h00, 1'b1);
        // no terminator: run then error
        add_byte(8'h10, 1'b0);
        add_byte(8'hFF, 1'b1);
        // ends on a count
        add_byte(8'h10, 1'b0);
        add_byte(8'h10, 1'b0);
        add_byte(8'h02, 1'b1);
        // terminator too early
        add_byte(8'h10, 1'b0);
        add_byte(8'h10, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b1);
        // count beyond the expected length
        add_byte(8'h10, 1'b0);
        add_byte(8'h10, 1'b0);
        add_byte(8'h05, 1'b0);
        add_byte(8'h00, 1'b1);
        play_stream();

        foreach (phase_lengths[p])
        begin
            wait_drained();
            write_length(16'(phase_lengths[p]));
            case (p % 4)
                0:
                begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
                1:
                begin
                    send_gap_pct = 69;
                    stall_pct    = 0;
                end
                2:
                begin
                    send_gap_pct = 0;
                    stall_pct    = 69;
                end
                default:
                begin
                    send_gap_pct = 23;
                    stall_pct    = 23;
                end
            endcase
            if (p == 2 || p == 5)
                hold_request = 1'b1;
            sent    = 0;
            streams = 0;
            while (sent < BYTES_PER_PHASE || streams < 4)
            begin
                build_random_stream(phase_lengths[p], streams == 0);
                sent += stream_q.size();
                streams++;
                play_stream();
            end
        end

        wait_drained();
        if (tracker.fail_count == 0 && tracker.due_runs.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
